[rtl/core/ccfp_pkg.sv]
// ----------------------------------------------------------------------------
// Command frame parser package
// Shared constants and types for the checksummed command frame parser.
// ----------------------------------------------------------------------------
package ccfp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned FRAME_LEN = 7;
    localparam int unsigned POS_W     = $clog2(FRAME_LEN + 1);

    localparam logic [POS_W-1:0] FIRST_POS = POS_W'(0);
    localparam logic [POS_W-1:0] CMD_POS   = POS_W'(2);
    localparam logic [POS_W-1:0] DEV_POS   = POS_W'(3);
    localparam logic [POS_W-1:0] LEVEL_POS = POS_W'(5);
    localparam logic [POS_W-1:0] CHECK_POS = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] FULL_POS  = POS_W'(FRAME_LEN);

    localparam logic [BYTE_W-1:0] START_BYTE  = 8'hFE;
    localparam logic [BYTE_W-1:0] CMD_CONTROL = 8'hA0;
    localparam logic [BYTE_W-1:0] DEV_LAMP    = 8'h02;
    localparam logic [BYTE_W-1:0] DEV_RELAY   = 8'h03;
    localparam logic [BYTE_W-1:0] LEVEL_ON    = 8'h01;

    typedef struct packed {
        logic valid;
        logic [BYTE_W-1:0] rx_byte;
    } stage_t;

    typedef struct packed {
        logic lamp_on;
        logic relay_on;
        logic frame_complete;
        logic checksum_ok;
    } result_t;

endpackage

[rtl/core/ccfp_byte_if.sv]
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel that carries one received serial byte per word.
// ----------------------------------------------------------------------------
interface ccfp_byte_if;

    logic valid;
    logic ready;
    logic [ccfp_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);

endinterface

[rtl/core/ccfp_status_if.sv]
// ----------------------------------------------------------------------------
// Status channel
// Valid/ready channel that carries the output levels and frame flags.
// ----------------------------------------------------------------------------
interface ccfp_status_if;

    logic valid;
    logic ready;
    logic lamp_on;
    logic relay_on;
    logic frame_complete;
    logic checksum_ok;

    modport source (output valid, output lamp_on, output relay_on,
                    output frame_complete, output checksum_ok, input ready);
    modport sink (input valid, input lamp_on, input relay_on,
                  input frame_complete, input checksum_ok, output ready);

endinterface

[rtl/core/checksummed_command_frame_parser_core.sv]
// ----------------------------------------------------------------------------
// Checksummed command frame parser core
// Parses seven byte command frames and drives the lamp and relay levels.
// ----------------------------------------------------------------------------
// The rx channel takes one received serial byte per word. A start byte of
// 0xFE opens a frame; the seventh byte closes it and is checked against the
// modulo 256 sum of the six bytes before it. A good frame with the control
// command sets the lamp or the relay level.
// The status channel returns exactly one word for every byte taken, in
// order, with both levels as they stand after that byte and the
// frame-complete and checksum-ok flags.
// A taken byte is held in the input register until the output register can
// load its status word; the word is then offered from the output register.
// One byte is taken per cycle while the status receiver does not stall; the
// frame position and the running checksum are updated as each byte is taken.
// When the status receiver stalls, the output register holds its word and
// the input register can still take one more byte before rx.ready drops.
// Reset clears the frame position, stops capture and turns both outputs off.
// ----------------------------------------------------------------------------
module checksummed_command_frame_parser_core
(
    input  logic    clk,
    input  logic    rst_n,
    ccfp_byte_if.sink     rx,
    ccfp_status_if.source status
);

    ccfp_pkg::stage_t  stage;
    ccfp_pkg::result_t result;
    ccfp_pkg::result_t out_word;
    logic              advance;

    ccfp_input_stage u_input
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_byte  (rx.rx_byte),
        .in_ready (rx.ready),
        .advance  (advance),
        .stage    (stage)
    );

    ccfp_frame_tracker u_tracker
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .advance (advance),
        .result  (result)
    );

    ccfp_result_stage u_result
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage.valid),
        .result    (result),
        .advance   (advance),
        .out_valid (status.valid),
        .out_word  (out_word),
        .out_ready (status.ready)
    );

    assign status.lamp_on        = out_word.lamp_on;
    assign status.relay_on       = out_word.relay_on;
    assign status.frame_complete = out_word.frame_complete;
    assign status.checksum_ok    = out_word.checksum_ok;

endmodule

[rtl/core/ccfp_input_stage.sv]
// ----------------------------------------------------------------------------
// Input stage
// Registers each received byte and releases it when the result stage moves.
// ----------------------------------------------------------------------------
module ccfp_input_stage
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [ccfp_pkg::BYTE_W-1:0]   in_byte,
    output logic                          in_ready,
    input  logic                          advance,
    output ccfp_pkg::stage_t              stage
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [ccfp_pkg::BYTE_W-1:0] byte_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
        end
    end

    assign stage.valid   = valid_reg;
    assign stage.rx_byte = byte_reg;

endmodule

[rtl/core/ccfp_frame_tracker.sv]
// ----------------------------------------------------------------------------
// Frame tracker
// Follows the frame position, keeps a running checksum and the command
// fields, and decodes complete frames into lamp and relay levels.
// ----------------------------------------------------------------------------
module ccfp_frame_tracker
(
    input  logic              clk,
    input  logic              rst_n,
    input  ccfp_pkg::stage_t  stage,
    input  logic              advance,
    output ccfp_pkg::result_t result
);

    logic                         capturing_reg;
    logic                         capturing_next;
    logic [ccfp_pkg::POS_W-1:0]   position_reg;
    logic [ccfp_pkg::POS_W-1:0]   position_next;
    logic [ccfp_pkg::BYTE_W-1:0]  sum_reg;
    logic [ccfp_pkg::BYTE_W-1:0]  sum_next;
    logic [ccfp_pkg::BYTE_W-1:0]  cmd_reg;
    logic [ccfp_pkg::BYTE_W-1:0]  dev_reg;
    logic                         level_reg;
    logic                         lamp_reg;
    logic                         lamp_next;
    logic                         relay_reg;
    logic                         relay_next;

    logic                         take;
    logic                         is_start;
    logic [ccfp_pkg::POS_W-1:0]   position_eff;
    logic                         store;
    logic                         complete;
    logic                         sum_match;
    logic                         command_hit;

    assign take         = stage.valid && advance;
    assign is_start     = (stage.rx_byte == ccfp_pkg::START_BYTE);
    assign position_eff = is_start ? ccfp_pkg::FIRST_POS : position_reg;
    assign store        = (capturing_reg || is_start) && (position_eff < ccfp_pkg::FULL_POS);
    assign complete     = store && (position_eff == ccfp_pkg::CHECK_POS);
    assign sum_match    = (sum_reg == stage.rx_byte);
    assign command_hit  = complete && sum_match && (cmd_reg == ccfp_pkg::CMD_CONTROL);

    always_comb
    begin
        capturing_next = capturing_reg || is_start;
        position_next  = store ? position_eff + ccfp_pkg::POS_W'(1) : position_eff;
        if (position_eff == ccfp_pkg::FIRST_POS)
        begin
            sum_next = stage.rx_byte;
        end
        else
        begin
            sum_next = sum_reg + stage.rx_byte;
        end
        lamp_next  = lamp_reg;
        relay_next = relay_reg;
        if (command_hit && (dev_reg == ccfp_pkg::DEV_LAMP))
        begin
            lamp_next = level_reg;
        end
        if (command_hit && (dev_reg == ccfp_pkg::DEV_RELAY))
        begin
            relay_next = level_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capturing_reg <= 1'b0;
            position_reg  <= ccfp_pkg::FIRST_POS;
            lamp_reg      <= 1'b0;
            relay_reg     <= 1'b0;
        end
        else if (take)
        begin
            capturing_reg <= capturing_next;
            position_reg  <= position_next;
            lamp_reg      <= lamp_next;
            relay_reg     <= relay_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && store)
        begin
            if (position_eff != ccfp_pkg::CHECK_POS)
            begin
                sum_reg <= sum_next;
            end
            if (position_eff == ccfp_pkg::CMD_POS)
            begin
                cmd_reg <= stage.rx_byte;
            end
            if (position_eff == ccfp_pkg::DEV_POS)
            begin
                dev_reg <= stage.rx_byte;
            end
            if (position_eff == ccfp_pkg::LEVEL_POS)
            begin
                level_reg <= (stage.rx_byte == ccfp_pkg::LEVEL_ON);
            end
        end
    end

    assign result.lamp_on        = lamp_next;
    assign result.relay_on       = relay_next;
    assign result.frame_complete = complete;
    assign result.checksum_ok    = complete && sum_match;

endmodule

[rtl/core/ccfp_result_stage.sv]
// ----------------------------------------------------------------------------
// Result stage
// Output register for the status word; loads whenever it is empty or the
// receiver takes the word it holds.
// ----------------------------------------------------------------------------
module ccfp_result_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  ccfp_pkg::result_t result,
    output logic              advance,
    output logic              out_valid,
    output ccfp_pkg::result_t out_word,
    input  logic              out_ready
);

    logic              valid_reg;
    logic              valid_next;
    ccfp_pkg::result_t word_reg;

    assign advance    = !valid_reg || out_ready;
    assign valid_next = advance ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            word_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

[rtl/core/ccfp_checker.sv]
// ----------------------------------------------------------------------------
// Command frame parser checker
// Port-level assertions on the parser core, attached by a bind statement.
// ----------------------------------------------------------------------------
module ccfp_checker
(
    input logic clk,
    input logic rst_n,
    input logic rx_ready,
    input logic st_valid,
    input logic st_ready,
    input logic lamp_on,
    input logic relay_on,
    input logic frame_complete,
    input logic checksum_ok
);

    logic lamp_seen_reg;
    logic relay_seen_reg;

    // The levels of the last delivered word, starting from the reset levels.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lamp_seen_reg  <= 1'b0;
            relay_seen_reg <= 1'b0;
        end
        else if (st_valid && st_ready)
        begin
            lamp_seen_reg  <= lamp_on;
            relay_seen_reg <= relay_on;
        end
    end

    a_ok_needs_complete: assert property (@(posedge clk) disable iff (!rst_n)
        st_valid |-> (!checksum_ok || frame_complete))
        else $error("checksum_ok without frame_complete");

    a_levels_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (st_valid && !checksum_ok) |->
            (lamp_on == lamp_seen_reg && relay_on == relay_seen_reg))
        else $error("output level changed without a good frame");

    a_one_output: assert property (@(posedge clk) disable iff (!rst_n)
        st_valid |-> !(lamp_on != lamp_seen_reg && relay_on != relay_seen_reg))
        else $error("lamp and relay changed in the same word");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !st_valid |-> rx_ready)
        else $error("input stalled while the output register is empty");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (st_valid && !st_ready) |=>
            (st_valid && $stable(lamp_on) && $stable(relay_on)
             && $stable(frame_complete) && $stable(checksum_ok)))
        else $error("stalled status word changed");

endmodule

bind checksummed_command_frame_parser_core ccfp_checker u_ccfp_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .rx_ready       (rx.ready),
    .st_valid       (status.valid),
    .st_ready       (status.ready),
    .lamp_on        (status.lamp_on),
    .relay_on       (status.relay_on),
    .frame_complete (status.frame_complete),
    .checksum_ok    (status.checksum_ok)
);
